// ----- sv/tcpq_pkg.sv -----
// tcpq_pkg: shared types and constants of the three-class priority scheduler
// no dependencies; imported by the interfaces, the scheduler and its checker
`default_nettype none

package tcpq_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int CLASS_W     = 2;
  localparam int RUN_W       = 4;
  localparam int COUNT_W     = 16;

  typedef logic [CLASS_W-1:0] class_t;
  typedef logic [RUN_W-1:0]   run_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam class_t CLASS_HIGH = 2'd0;
  localparam class_t CLASS_MID  = 2'd1;
  localparam class_t CLASS_LOW  = 2'd2;

  localparam run_t   RUN_MAX         = 4'd15;
  localparam run_t   RUN_LIMIT_RESET = 4'd3;
  localparam count_t COUNT_MAX       = 16'hffff;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SERVE   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_SERVED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ----- sv/tcpq_ifs.sv -----
// tcpq_in_if and tcpq_out_if: valid/ready channels of the scheduler
// depends on tcpq_pkg
`default_nettype none

interface tcpq_in_if #(
  parameter int TAG_BITS = 32
);
  import tcpq_pkg::*;

  logic                valid;
  logic                ready;
  op_e                 op;
  class_t              priority_class;
  logic [TAG_BITS-1:0] item_tag;

  modport source (output valid, output op, output priority_class, output item_tag,
                  input ready);
  modport sink   (input valid, input op, input priority_class, input item_tag,
                  output ready);
endinterface

interface tcpq_out_if #(
  parameter int TAG_BITS = 32
);
  import tcpq_pkg::*;

  logic                valid;
  logic                ready;
  status_e             status;
  logic [TAG_BITS-1:0] served_tag;
  class_t              served_class;
  count_t              highest_served_count;
  count_t              middle_served_count;
  count_t              lowest_served_count;

  modport source (output valid, output status, output served_tag, output served_class,
                  output highest_served_count, output middle_served_count,
                  output lowest_served_count, input ready);
  modport sink   (input valid, input status, input served_tag, input served_class,
                  input highest_served_count, input middle_served_count,
                  input lowest_served_count, output ready);
endinterface

`default_nettype wire

// ----- sv/tcpq_ram.sv -----
// tcpq_ram: generic one-write one-read memory with registered read data
// no dependencies
`default_nettype none

module tcpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 192,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/three_class_priority_queue_scheduler.sv -----
// three_class_priority_queue_scheduler: three tag FIFOs in one shared RAM,
// strict priority service with a run limit on the middle class
// depends on tcpq_pkg, tcpq_ifs (tcpq_in_if, tcpq_out_if) and tcpq_ram
//
//  channel  dir  handshake        payload
//  in_i     in   valid/ready      op, priority_class, item_tag
//  out_o    out  valid/ready      status, served_tag, served_class, three counts
//  cfg      in   cfg_we_i only    cfg_wdata_i = middle_run_limit
//
// an enqueue, a rejected enqueue or a serve with nothing waiting sets the result register directly
// a serve reads the tag RAM at the head pointer, then S_READ loads its registered data as the result
// the next item is taken, in S_IDLE only, in the cycle its result register is empty or is transferred
// reset clears pointers, fill levels, run count, counters and the limit (to 3)
// the tag RAM needs no clearing: only entries holding a queued tag are read
`default_nettype none

module three_class_priority_queue_scheduler #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire tcpq_pkg::run_t         cfg_wdata_i,
  tcpq_in_if.sink                     in_i,
  tcpq_out_if.source                  out_o
);
  import tcpq_pkg::*;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e              state_q;
  logic [PTR_W-1:0]    head_q [NUM_CLASSES];
  logic [PTR_W-1:0]    tail_q [NUM_CLASSES];
  logic [FILL_W-1:0]   fill_q [NUM_CLASSES];
  count_t              cnt_q  [NUM_CLASSES];
  run_t                run_q;
  run_t                limit_q;
  class_t              sel_class_q;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [TAG_BITS-1:0] out_tag_q;
  class_t              out_class_q;

  logic                in_ready;
  logic                in_xfer;
  logic                is_enq;
  class_t              enq_class;
  logic                enq_full;
  logic                serve_hit;
  class_t              sel_class;
  logic                out_set;
  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [TAG_BITS-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(input class_t c,
                                                   input logic [PTR_W-1:0] p);
    return ADDR_W'(c) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
  endfunction

  assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_xfer   = in_i.valid && in_ready;
  assign is_enq    = (in_i.op == OP_ENQUEUE);
  assign enq_class = (in_i.priority_class > CLASS_LOW) ? CLASS_LOW : in_i.priority_class;
  assign enq_full  = (fill_q[enq_class] == FILL_W'(QUEUE_DEPTH));

  always_comb begin
    serve_hit = 1'b1;
    sel_class = CLASS_HIGH;
    priority if (fill_q[CLASS_HIGH] != '0) begin
      sel_class = CLASS_HIGH;
    end else if (fill_q[CLASS_MID] != '0 && run_q < limit_q) begin
      sel_class = CLASS_MID;
    end else if (fill_q[CLASS_LOW] != '0) begin
      sel_class = CLASS_LOW;
    end else if (fill_q[CLASS_MID] != '0) begin
      sel_class = CLASS_MID;
    end else begin
      serve_hit = 1'b0;
    end
  end

  assign out_set   = (state_q == S_READ) || (in_xfer && (is_enq || !serve_hit));

  assign ram_we    = in_xfer && is_enq && !enq_full;
  assign ram_re    = in_xfer && !is_enq && serve_hit;
  assign ram_waddr = entry_addr(enq_class, tail_q[enq_class]);
  assign ram_raddr = entry_addr(sel_class, head_q[sel_class]);

  tcpq_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (ENTRIES),
    .ADDR_W(ADDR_W)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_i.item_tag),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      run_q        <= '0;
      limit_q      <= RUN_LIMIT_RESET;
      sel_class_q  <= CLASS_HIGH;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_ENQUEUED;
      out_tag_q    <= '0;
      out_class_q  <= CLASS_HIGH;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_o.ready && !out_set) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (is_enq) begin
              out_valid_q <= 1'b1;
              out_tag_q   <= '0;
              out_class_q <= CLASS_HIGH;
              if (enq_full) begin
                out_status_q <= ST_FULL;
              end else begin
                out_status_q      <= ST_ENQUEUED;
                tail_q[enq_class] <= advance(tail_q[enq_class]);
                fill_q[enq_class] <= fill_q[enq_class] + 1'b1;
              end
            end else if (serve_hit) begin
              head_q[sel_class] <= advance(head_q[sel_class]);
              fill_q[sel_class] <= fill_q[sel_class] - 1'b1;
              if (cnt_q[sel_class] != COUNT_MAX) begin
                cnt_q[sel_class] <= cnt_q[sel_class] + 1'b1;
              end
              if (sel_class == CLASS_MID) begin
                if (run_q != RUN_MAX) begin
                  run_q <= run_q + 1'b1;
                end
              end else if (sel_class == CLASS_LOW) begin
                run_q <= '0;
              end
              sel_class_q <= sel_class;
              state_q     <= S_READ;
            end else begin
              out_valid_q  <= 1'b1;
              out_status_q <= ST_EMPTY;
              out_tag_q    <= '0;
              out_class_q  <= CLASS_HIGH;
            end
          end
        end
        S_READ: begin
          out_valid_q  <= 1'b1;
          out_status_q <= ST_SERVED;
          out_tag_q    <= ram_rdata;
          out_class_q  <= sel_class_q;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready                 = in_ready;
  assign out_o.valid                = out_valid_q;
  assign out_o.status               = out_status_q;
  assign out_o.served_tag           = out_tag_q;
  assign out_o.served_class         = out_class_q;
  assign out_o.highest_served_count = cnt_q[CLASS_HIGH];
  assign out_o.middle_served_count  = cnt_q[CLASS_MID];
  assign out_o.lowest_served_count  = cnt_q[CLASS_LOW];

endmodule

`default_nettype wire

// ----- sv/tcpq_checker.sv -----
// tcpq_checker: port-level assertions on the scheduler result channel
// depends on tcpq_pkg; bound to three_class_priority_queue_scheduler below
`default_nettype none

module tcpq_checker #(
  parameter int TAG_BITS = 32
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire tcpq_pkg::status_e   out_status_i,
  input wire logic [TAG_BITS-1:0] out_tag_i,
  input wire tcpq_pkg::class_t    out_class_i,
  input wire tcpq_pkg::count_t    highest_count_i,
  input wire tcpq_pkg::count_t    middle_count_i,
  input wire tcpq_pkg::count_t    lowest_count_i
);
  import tcpq_pkg::*;

  // stalled result holds until transfer
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_status_i) && $stable(out_tag_i) && $stable(out_class_i))
    else $error("result changed while stalled");

  // served counters never go down
  a_counts_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    highest_count_i >= $past(highest_count_i) &&
    middle_count_i >= $past(middle_count_i) &&
    lowest_count_i >= $past(lowest_count_i))
    else $error("served counter decreased");

  // tag and class are zero unless served
  a_zero_unserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_SERVED |-> out_tag_i == '0 && out_class_i == CLASS_HIGH)
    else $error("tag or class set on a non-served result");

  // a served result has been counted in its class
  a_served_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_SERVED |->
      (out_class_i == CLASS_HIGH && highest_count_i != '0) ||
      (out_class_i == CLASS_MID && middle_count_i != '0) ||
      (out_class_i == CLASS_LOW && lowest_count_i != '0))
    else $error("served result without a matching count");

endmodule

bind three_class_priority_queue_scheduler tcpq_checker #(
  .TAG_BITS(TAG_BITS)
) u_tcpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_status_i   (out_o.status),
  .out_tag_i      (out_o.served_tag),
  .out_class_i    (out_o.served_class),
  .highest_count_i(out_o.highest_served_count),
  .middle_count_i (out_o.middle_served_count),
  .lowest_count_i (out_o.lowest_served_count)
);

`default_nettype wire

// ----- bench/three_class_priority_queue_scheduler_tb.sv -----
// three_class_priority_queue_scheduler_tb: self-checking bench for the three-class scheduler
// predicts every transfer with a queue-based model of strict priority and the middle run limit
// depends on tcpq_pkg, tcpq_ifs and three_class_priority_queue_scheduler
module three_class_priority_queue_scheduler_tb;
  import tcpq_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int TAG_BITS = 32;
  localparam class_t CLASS_ALIAS_LOW = 2'd3;

  typedef struct {
    op_e                 op;
    class_t              cls;
    logic [TAG_BITS-1:0] tag;
  } sched_req_t;

  typedef struct {
    status_e             status;
    logic [TAG_BITS-1:0] tag;
    class_t              cls;
    count_t              high_cnt;
    count_t              mid_cnt;
    count_t              low_cnt;
  } sched_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we = 1'b0;
  run_t                cfg_wdata = '0;
  logic                drv_valid = 1'b0;
  op_e                 drv_op = OP_ENQUEUE;
  class_t              drv_class = CLASS_HIGH;
  logic [TAG_BITS-1:0] drv_tag = '0;
  logic                sink_ready = 1'b0;
  bit                  steady = 1'b0;

  sched_req_t          stim_items[$];
  sched_req_t          cur_item;
  sched_reply_t        expected_replies[$];
  int                  pushed_count = 0;
  int                  accepted_count = 0;
  int                  fail_count = 0;

  logic [TAG_BITS-1:0] high_tags[$];
  logic [TAG_BITS-1:0] mid_tags[$];
  logic [TAG_BITS-1:0] low_tags[$];
  run_t                mid_run = '0;
  run_t                run_limit = RUN_LIMIT_RESET;
  count_t              served_totals[NUM_CLASSES] = '{default: '0};

  tcpq_in_if  #(.TAG_BITS(TAG_BITS)) in_ch ();
  tcpq_out_if #(.TAG_BITS(TAG_BITS)) out_ch ();

  assign in_ch.valid          = drv_valid;
  assign in_ch.op             = drv_op;
  assign in_ch.priority_class = drv_class;
  assign in_ch.item_tag       = drv_tag;
  assign out_ch.ready         = sink_ready;

  three_class_priority_queue_scheduler #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS(TAG_BITS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i(in_ch),
    .out_o(out_ch)
  );

  always #5 clk_i = ~clk_i;

  task automatic schedule_step(input sched_req_t it);
    sched_reply_t r;
    class_t       c;
    bit           full;
    r.status = ST_ENQUEUED;
    r.tag = '0;
    r.cls = CLASS_HIGH;
    c = CLASS_LOW;
    if (it.op == OP_ENQUEUE) begin
      c = (it.cls > CLASS_LOW) ? CLASS_LOW : it.cls;
      full = (c == CLASS_HIGH) ? (high_tags.size() >= QUEUE_DEPTH) :
             (c == CLASS_MID)  ? (mid_tags.size() >= QUEUE_DEPTH) :
                                 (low_tags.size() >= QUEUE_DEPTH);
      if (full) begin
        r.status = ST_FULL;
      end else begin
        case (c)
          CLASS_HIGH: high_tags.push_back(it.tag);
          CLASS_MID:  mid_tags.push_back(it.tag);
          default:    low_tags.push_back(it.tag);
        endcase
      end
    end else begin
      r.status = ST_SERVED;
      if (high_tags.size() != 0) c = CLASS_HIGH;
      else if (mid_tags.size() != 0 && mid_run < run_limit) c = CLASS_MID;
      else if (low_tags.size() != 0) c = CLASS_LOW;
      else if (mid_tags.size() != 0) c = CLASS_MID;
      else r.status = ST_EMPTY;
      if (r.status == ST_SERVED) begin
        r.cls = c;
        case (c)
          CLASS_HIGH: r.tag = high_tags.pop_front();
          CLASS_MID: begin
            r.tag = mid_tags.pop_front();
            if (mid_run != RUN_MAX) mid_run = mid_run + 1'b1;
          end
          default: begin
            r.tag = low_tags.pop_front();
            mid_run = '0;
          end
        endcase
        if (served_totals[c] != COUNT_MAX) served_totals[c] = served_totals[c] + 1'b1;
      end
    end
    r.high_cnt = served_totals[CLASS_HIGH];
    r.mid_cnt  = served_totals[CLASS_MID];
    r.low_cnt  = served_totals[CLASS_LOW];
    expected_replies.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // request side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (drv_valid && in_ch.ready) begin
        schedule_step(cur_item);
        accepted_count++;
      end
      if (!drv_valid || in_ch.ready) begin
        if (stim_items.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
          cur_item = stim_items.pop_front();
          drv_valid <= 1'b1;
          drv_op    <= cur_item.op;
          drv_class <= cur_item.cls;
          drv_tag   <= cur_item.tag;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // reply side
  always @(posedge clk_i) begin
    sched_reply_t want;
    if (rst_ni) begin
      if (out_ch.valid && sink_ready) begin
        if (expected_replies.size() == 0) begin
          $error("transfer with no reply pending: status %0d", out_ch.status);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("served_tag", want.tag, out_ch.served_tag);
          check_field("served_class", want.cls, out_ch.served_class);
          check_field("highest_served_count", want.high_cnt, out_ch.highest_served_count);
          check_field("middle_served_count", want.mid_cnt, out_ch.middle_served_count);
          check_field("lowest_served_count", want.low_cnt, out_ch.lowest_served_count);
        end
      end
      sink_ready <= steady || ($urandom_range(99) >= 29);
    end
  end

  task automatic push_item(input op_e op, input class_t cls, input logic [TAG_BITS-1:0] tag);
    sched_req_t it;
    it.op = op;
    it.cls = cls;
    it.tag = tag;
    stim_items.push_back(it);
    pushed_count++;
  endtask

  function automatic logic [TAG_BITS-1:0] rand_tag();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic class_t rand_class();
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) return CLASS_HIGH;
    if (pick < 6) return CLASS_MID;
    if (pick < 9) return CLASS_LOW;
    return CLASS_ALIAS_LOW;
  endfunction

  task automatic wait_drained();
    while (!(accepted_count == pushed_count && expected_replies.size() == 0))
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_run_limit(input run_t value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    run_limit = value;
  endtask

  task automatic random_phase(input int n);
    int     made;
    int     kind;
    int     len;
    class_t c;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        // overfill one class
        c = class_t'($urandom_range(3));
        repeat (QUEUE_DEPTH + 2) push_item(OP_ENQUEUE, c, rand_tag());
        made += QUEUE_DEPTH + 2;
      end else if (kind < 35) begin
        len = $urandom_range(10, 70);
        repeat (len) push_item(OP_SERVE, rand_class(), rand_tag());
        made += len;
      end else begin
        len = $urandom_range(5, 30);
        repeat (len)
          push_item(($urandom_range(99) < 45) ? OP_SERVE : OP_ENQUEUE, rand_class(), rand_tag());
        made += len;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_item(OP_SERVE, CLASS_MID, 32'h0);
    push_item(OP_ENQUEUE, CLASS_HIGH, 32'h0000_0000);
    push_item(OP_ENQUEUE, CLASS_HIGH, 32'hffff_ffff);
    repeat (4) push_item(OP_ENQUEUE, CLASS_MID, $urandom);
    push_item(OP_ENQUEUE, CLASS_LOW, 32'h8000_0000);
    push_item(OP_ENQUEUE, CLASS_ALIAS_LOW, 32'h7fff_ffff);
    repeat (10) push_item(OP_SERVE, rand_class(), rand_tag());
    wait_drained();

    write_run_limit(4'd0);
    random_phase(160);
    write_run_limit(4'd1);
    random_phase(160);
    write_run_limit(RUN_MAX);
    random_phase(160);
    write_run_limit(run_t'($urandom_range(2, 14)));
    random_phase(160);
    steady = 1'b1;
    write_run_limit(RUN_LIMIT_RESET);
    random_phase(160);
    steady = 1'b0;
    random_phase(40);

    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
